FILE: design/keypad_change_event_fifo_macros.svh
// assertion macros used by the keypad change event fifo engine
// no dependencies; included inside module bodies
`ifndef KEYPAD_CHANGE_EVENT_FIFO_MACROS_SVH
`define KEYPAD_CHANGE_EVENT_FIFO_MACROS_SVH

// same-cycle implication, disabled during reset
`define KCEF_CHECK_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("keypad event fifo: same-cycle check failed");

// next-cycle implication, disabled during reset
`define KCEF_CHECK_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("keypad event fifo: next-cycle check failed");

`endif

FILE: design/kcef_pkg.sv
// shared constants, types and helper functions of the keypad change event fifo
// no dependencies
`timescale 1ns / 1ps

package kcef_pkg;

   localparam int ROWS         = 8;
   localparam int COLS         = 8;
   localparam int FIFO_DEPTH   = 128;
   localparam int RELEASE_FLAG = 128;

   localparam int KEYS        = 64;
   localparam int KEY_W       = 6;
   localparam int CODE_W      = 8;
   localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic {
      CMD_SCAN = 1'b0,
      CMD_POP  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [KEYS-1:0]   bits;
   } cmd_entry_type;

   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } head_type;

   typedef enum logic {
      ENG_IDLE,
      ENG_SCAN
   } eng_state_type;

   // keys that lie inside the matrix
   function automatic logic [KEYS-1:0] key_mask_calc();
      logic [KEYS-1:0] m;
      m = '0;
      for (int p = 0; p < KEYS; p++) begin
         if (((p / 8) < ROWS) && ((p % 8) < COLS)) begin
            m[p] = 1'b1;
         end
      end
      return m;
   endfunction

   localparam logic [KEYS-1:0] KEY_MASK = key_mask_calc();

   // ring pointer step with wrap at the end of the ring
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

FILE: design/kcef_cmd_queue.sv
// front end: accepts requests, classifies them and queues them for the engine
// depends on kcef_pkg
`timescale 1ns / 1ps

module kcef_cmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,   // scan_bits
   input  logic [0:0]                  req_tuser,   // cmd
   output kcef_pkg::head_type          head,
   input  logic                        head_take
);
   import kcef_pkg::*;

   cmd_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;
   cmd_entry_type     new_entry;

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = head_take && head.valid;

   always_comb begin
      new_entry.kind = req_tuser[0] ? CMD_POP : CMD_SCAN;
      new_entry.bits = req_tdata;
   end

   always_comb begin
      wr_idx_in = push ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = pop  ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   // head: valid flag over the oldest queued entry
   assign head = {(count_ff != '0), slot_ff[rd_idx_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= new_entry;
      end
   end

endmodule

FILE: design/kcef_engine.sv
// back end: walks scans against the stored snapshot, fills the event ring, serves pops
// depends on kcef_pkg and keypad_change_event_fifo_macros.svh
`timescale 1ns / 1ps

module kcef_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  kcef_pkg::head_type          head,
   output logic                        head_take,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // key_code
   output logic [0:0]                  rsp_tuser    // key_valid
);
   import kcef_pkg::*;
   `include "keypad_change_event_fifo_macros.svh"

   eng_state_type     state_ff, state_in;
   logic [KEY_W-1:0]  pos_ff, pos_in;
   logic [KEYS-1:0]   now_ff, now_in;
   logic [KEYS-1:0]   prev_ff, prev_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_flag_ff;

   logic [CODE_W-1:0] ring_mem [FIFO_DEPTH];
   logic              ring_we;
   logic [CODE_W-1:0] ring_wdata;
   logic              ring_empty;
   logic              pop_load;
   logic              in_matrix;
   logic              was_pressed;
   logic              key_changed;

   assign ring_empty  = (rd_ptr_ff == wr_ptr_ff);
   assign in_matrix   = (int'(pos_ff[5:3]) < ROWS) && (int'(pos_ff[2:0]) < COLS);
   assign was_pressed = prev_ff[pos_ff];
   assign key_changed = in_matrix && (prev_ff[pos_ff] != now_ff[pos_ff]);
   assign ring_wdata  = {2'b00, pos_ff} | (was_pressed ? CODE_W'(RELEASE_FLAG) : '0);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      now_in       = now_ff;
      prev_in      = prev_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      head_take    = 1'b0;
      pop_load     = 1'b0;
      ring_we      = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (head.valid) begin
               if (head.entry.kind == CMD_SCAN) begin
                  head_take = 1'b1;
                  now_in    = head.entry.bits;
                  pos_in    = '0;
                  state_in  = ENG_SCAN;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  head_take    = 1'b1;
                  pop_load     = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (!ring_empty) begin
                     rd_ptr_in = ptr_next(rd_ptr_ff);
                  end
               end
            end
         end
         ENG_SCAN: begin
            if (key_changed) begin
               ring_we   = 1'b1;
               wr_ptr_in = ptr_next(wr_ptr_ff);
            end
            pos_in = pos_ff + 1'b1;
            if (pos_ff == KEY_W'(KEYS - 1)) begin
               prev_in  = now_ff & KEY_MASK;
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         prev_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      now_ff <= now_in;
   end

   // event ring, read data lands straight in the response register
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wr_ptr_ff] <= ring_wdata;
      end
      if (pop_load) begin
         rsp_flag_ff <= !ring_empty;
         rsp_code_ff <= ring_empty ? '0 : ring_mem[rd_ptr_ff];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_code_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

   `KCEF_CHECK_NEXT(a_walk_ends, clock, reset, (state_ff == ENG_SCAN) && (pos_ff == KEY_W'(KEYS - 1)), state_ff == ENG_IDLE)
   `KCEF_CHECK_NEXT(a_wr_ptr_idle, clock, reset, state_ff == ENG_IDLE, wr_ptr_ff == $past(wr_ptr_ff))
   `KCEF_CHECK_NOW(a_pop_has_room, clock, reset, head_take && (head.entry.kind == CMD_POP), !rsp_valid_ff || rsp_tready)
   `KCEF_CHECK_NOW(a_no_take_in_walk, clock, reset, state_ff == ENG_SCAN, !head_take)

endmodule

FILE: design/keypad_change_event_fifo.sv
// top level of the keypad change event fifo: command queue in front, scan/pop engine behind
// depends on kcef_pkg, kcef_cmd_queue and kcef_engine
`timescale 1ns / 1ps

//  channel | dir | tdata             | tuser         | moves
//  req_    | in  | scan_bits [63:0]  | cmd [0]       | one scan or pop request
//  rsp_    | out | key_code  [7:0]   | key_valid [0] | one popped event per pop request
//
//  a scan loads the request bits, then walks the 64 key positions in order, making at most
//  one ring write per position through the single write port of the event ring
//  a pop reads the ring straight into the registered response
//  a two-entry request queue lets requests land while the engine walks a scan
//  reset is synchronous: snapshot and pointers clear, ring contents are left as they are
//  a stalled response holds the engine only when the next queued request is a pop

module keypad_change_event_fifo (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // scan_bits
   input  logic [0:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // key_code
   output logic [0:0]  rsp_tuser    // key_valid
);
   import kcef_pkg::*;

   // oldest queued request as seen by the engine
   head_type head;
   // engine consumes the queue head
   logic     head_take;

   // front end: request acceptance and classification
   kcef_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .head_take  (head_take)
   );

   // back end: key walk, event ring and response register
   kcef_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_take  (head_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sim/keypad_change_event_fifo_test.sv
// self-checking testbench for keypad_change_event_fifo: scan and pop requests against a ring predictor
// depends on kcef_pkg and the keypad_change_event_fifo rtl
`timescale 1ns / 1ps

module keypad_change_event_fifo_test;
   import kcef_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int TARGET_ITEMS = 1170;
   localparam int PHASE_ITEMS  = 145;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } key_event_type;

   // tracks the snapshot and the event ring, queues the responses pops will produce
   class key_event_scoreboard;
      logic [KEYS-1:0]   held_scan;
      logic [CODE_W-1:0] ring [FIFO_DEPTH];
      int                wr_ptr;
      int                rd_ptr;
      key_event_type     expected_events[$];
      int                mismatches;

      function new();
         held_scan  = '0;
         wr_ptr     = 0;
         rd_ptr     = 0;
         mismatches = 0;
      endfunction

      function void push_code(logic [CODE_W-1:0] code);
         ring[wr_ptr] = code;
         wr_ptr       = (wr_ptr + 1) % FIFO_DEPTH;
      endfunction

      // an accepted request: a scan pushes change events, a pop queues one response
      function void note_request(cmd_kind_type kind, logic [KEYS-1:0] bits);
         logic [KEYS-1:0] kept;
         key_event_type   ev;
         int              pos;
         if (kind == CMD_SCAN) begin
            kept = '0;
            for (int row = 0; row < ROWS; row++) begin
               for (int col = 0; col < COLS; col++) begin
                  pos = row * 8 + col;
                  if (held_scan[pos] && !bits[pos]) begin
                     push_code(CODE_W'(pos) | CODE_W'(RELEASE_FLAG));
                  end else if (!held_scan[pos] && bits[pos]) begin
                     push_code(CODE_W'(pos));
                  end
                  kept[pos] = bits[pos];
               end
            end
            held_scan = kept;
         end else begin
            if (rd_ptr == wr_ptr) begin
               ev = '0;
            end else begin
               ev.valid = 1'b1;
               ev.code  = ring[rd_ptr];
               rd_ptr   = (rd_ptr + 1) % FIFO_DEPTH;
            end
            expected_events.push_back(ev);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_response(logic valid, logic [CODE_W-1:0] code);
         key_event_type ev;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected response valid=%0b code=%02h", valid, code));
         end else begin
            ev = expected_events.pop_front();
            if (valid !== ev.valid) begin
               report_mismatch($sformatf("key_valid %0b, expected %0b", valid, ev.valid));
            end
            if (code !== ev.code) begin
               report_mismatch($sformatf("key_code %02h, expected %02h", code, ev.code));
            end
         end
      endtask

      function int outstanding();
         return expected_events.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;

   key_event_scoreboard key_events = new();

   int          idle_pct   = 0;
   int          stall_pct  = 0;
   int          sent_items = 0;
   int          cycles     = 0;
   logic [63:0] last_scan  = '0;

   keypad_change_event_fifo i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // scan_bits
      .req_tuser  (req_tuser),    // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // key_code
      .rsp_tuser  (rsp_tuser)     // key_valid
   );

   always #5 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("keypad_change_event_fifo_test NOT OK");
         $finish;
      end
   end

   // response side: random back-pressure, every accepted response checked in order
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         key_events.check_response(rsp_tuser[0], rsp_tdata);
      end
   end

   // one request: optional idle gap, then hold valid until the block takes it
   task automatic send_request(input cmd_kind_type kind, input logic [63:0] bits);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      key_events.note_request(kind, bits);
      if (kind == CMD_SCAN) begin
         last_scan = bits;
      end
      sent_items++;
   endtask

   // sender holds off until every queued response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (key_events.outstanding() != 0);
   endtask

   initial begin
      logic [63:0] next_scan;
      int          choice;
      int          phase;
      int          cur_phase;
      int          pops;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, corner keys pressed and released, overflow, pops with junk data
      send_request(CMD_POP, '0);
      send_request(CMD_SCAN, '0);
      send_request(CMD_SCAN, 64'h8000_0000_0000_0001);
      send_request(CMD_POP, '1);
      send_request(CMD_POP, 64'h5555_5555_5555_5555);
      send_request(CMD_POP, '0);
      send_request(CMD_SCAN, '0);
      send_request(CMD_POP, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CMD_POP, '0);
      // 128 pushes with no pop: write pointer laps the read pointer, ring looks empty
      send_request(CMD_SCAN, '1);
      send_request(CMD_SCAN, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_SCAN, 64'hA5A5_A5A5_A5A5_A5A5);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '1);
      send_request(CMD_SCAN, '1);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      wait_drained();

      // random: mostly a small change followed by about as many pops, some bulk scans and noise
      cur_phase = -1;
      while (sent_items < TARGET_ITEMS) begin
         phase = (sent_items / PHASE_ITEMS) % 4;
         if (phase != cur_phase) begin
            wait_drained();
            cur_phase = phase;
            case (phase)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 48; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 48; end
               default: begin idle_pct = 12; stall_pct = 12; end
            endcase
         end
         choice = $urandom_range(99);
         if (choice < 75) begin
            next_scan = last_scan;
            repeat ($urandom_range(1, 4)) next_scan[$urandom_range(63)] ^= 1'b1;
            pops = $countones(next_scan ^ last_scan) + $urandom_range(0, 2) - 1;
            send_request(CMD_SCAN, next_scan);
            repeat ((pops < 0) ? 0 : pops) send_request(CMD_POP, {$urandom, $urandom});
         end else if (choice < 87) begin
            case ($urandom_range(7))
               0: next_scan = '1;
               1: next_scan = '0;
               default: next_scan = {$urandom, $urandom};
            endcase
            send_request(CMD_SCAN, next_scan);
            repeat ($urandom_range(20, 70)) send_request(CMD_POP, {$urandom, $urandom});
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(1)) begin
                  send_request(CMD_POP, {$urandom, $urandom});
               end else begin
                  send_request(CMD_SCAN, {$urandom, $urandom});
               end
            end
         end
      end

      // drain, then give a trailing scan time to finish and catch stray responses
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (key_events.outstanding() != 0) begin
         key_events.report_mismatch("responses still missing at end of run");
      end
      if (key_events.mismatches == 0) begin
         $display("keypad_change_event_fifo_test OK");
      end else begin
         $display("keypad_change_event_fifo_test NOT OK");
      end
      $finish;
   end

endmodule

FILE: keypad_change_event_fifo.f
+incdir+design
design/kcef_pkg.sv
design/kcef_cmd_queue.sv
design/kcef_engine.sv
design/keypad_change_event_fifo.sv
sim/keypad_change_event_fifo_test.sv
